// File: design/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define SLT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define SLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/slt_pkg.sv
// ============================================================================
// Swing level tracker package
// Shared constants, sequencer states and control types.
// ============================================================================
package slt_pkg;

    // Width of prices in ticks and of bar indices, in bits.
    localparam int PRICE_W = 32;

    // Largest supported neighbour count by default.
    localparam int MAX_LEN_DEFAULT = 64;

    // Width and reset value of the swing length register.
    localparam int LEN_CFG_W = 7;
    localparam logic [LEN_CFG_W-1:0] SWING_LENGTH_RESET = 7'd5;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DECIDE,
        ST_CONFIRM,
        ST_EVAL
    } state_t;

    // Controls from the sequencer to the history and compare unit.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic acc_clear;
    } hist_ctrl_t;

endpackage

// File: design/slt_history.sv
// ============================================================================
// Swing level tracker history
// Ring memory of finished bar highs and lows, with the shared compare unit
// that folds one stored bar per cycle into the window maximum and minimum.
// ============================================================================
module slt_history #(
    parameter int DEPTH = slt_pkg::MAX_LEN_DEFAULT + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  slt_pkg::hist_ctrl_t           ctrl,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [slt_pkg::PRICE_W-1:0]   wr_high,
    input  logic [slt_pkg::PRICE_W-1:0]   wr_low,
    input  logic [AW-1:0]                 rd_addr,
    output logic [slt_pkg::PRICE_W-1:0]   win_max,
    output logic [slt_pkg::PRICE_W-1:0]   win_min
);

    // Each word holds the high in its upper half and the low in its lower half.
    logic [2*slt_pkg::PRICE_W-1:0] mem [DEPTH];
    logic [2*slt_pkg::PRICE_W-1:0] rd_data_reg;
    logic                          rd_vld_reg;
    logic [slt_pkg::PRICE_W-1:0]   max_reg;
    logic [slt_pkg::PRICE_W-1:0]   min_reg;
    logic [slt_pkg::PRICE_W-1:0]   rd_high;
    logic [slt_pkg::PRICE_W-1:0]   rd_low;

    // Memory write port and registered read port.
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= {wr_high, wr_low};
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // The read data is valid in the cycle after a read is issued.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= ctrl.rd_en;
        end
    end

    assign rd_high = rd_data_reg[2*slt_pkg::PRICE_W-1:slt_pkg::PRICE_W];
    assign rd_low  = rd_data_reg[slt_pkg::PRICE_W-1:0];

    // Shared compare unit: one stored bar folded into the running extremes per cycle.
    always_ff @(posedge aclk) begin
        if (ctrl.acc_clear) begin
            max_reg <= '0;
            min_reg <= '1;
        end else if (rd_vld_reg) begin
            if (rd_high > max_reg) begin
                max_reg <= rd_high;
            end
            if (rd_low < min_reg) begin
                min_reg <= rd_low;
            end
        end
    end

    assign win_max = max_reg;
    assign win_min = min_reg;

endmodule

// File: design/swing_level_tracker_top.sv
// ============================================================================
// Swing level tracker
// Tracks swing high and swing low pivot levels on a stream of price bar
// updates, reports confirmations and shows active levels until breached.
// ============================================================================
//
//  Channel  Direction  Handshake            Contents
//  s_       in         s_valid / s_ready    bar high, bar low, new bar flag
//  m_       out        m_valid / m_ready    bar number, levels, confirm events
//  cfg_     in         cfg_wr_en only       swing length N (7 bits)
//
// An update that does not start a new bar, and the first update, go straight
// to the final step. A new bar once the index is above N first scans the window,
// one stored bar per cycle through the single read port of the history memory.
// The result sits in an output register, so the next transfer is accepted
// while it waits; the block only stalls at the final step if it is still held.
// Reset is synchronous and active low; the history memory needs no clearing.
//
`include "assert_macros.svh"

module swing_level_tracker_top #(
    parameter int MAX_LEN = slt_pkg::MAX_LEN_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [slt_pkg::LEN_CFG_W-1:0]   cfg_wr_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [slt_pkg::PRICE_W-1:0]     s_bar_high,
    input  logic [slt_pkg::PRICE_W-1:0]     s_bar_low,
    input  logic                            s_new_bar,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [slt_pkg::PRICE_W-1:0]     m_bar_number,
    output logic [slt_pkg::PRICE_W-1:0]     m_high_level,
    output logic                            m_high_shown,
    output logic [slt_pkg::PRICE_W-1:0]     m_low_level,
    output logic                            m_low_shown,
    output logic                            m_high_confirmed,
    output logic [slt_pkg::PRICE_W-1:0]     m_high_swing_bar,
    output logic                            m_low_confirmed,
    output logic [slt_pkg::PRICE_W-1:0]     m_low_swing_bar
);

    localparam int PW    = slt_pkg::PRICE_W;
    localparam int DEPTH = MAX_LEN + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int CW    = (LW > slt_pkg::LEN_CFG_W) ? LW : slt_pkg::LEN_CFG_W;

    slt_pkg::state_t      state_reg, state_next;
    slt_pkg::hist_ctrl_t  hist_ctrl;

    logic [slt_pkg::LEN_CFG_W-1:0] swing_length_reg;
    logic [CW-1:0]        cfg_ext;
    logic [LW-1:0]        len_eff;
    logic [LW-1:0]        len_reg;
    logic [LW-1:0]        remain_reg;
    logic [PW-1:0]        len32;

    logic                 s_accept;
    logic                 out_free;
    logic                 out_load;

    logic [PW-1:0]        in_high_reg;
    logic [PW-1:0]        in_low_reg;
    logic [PW-1:0]        current_high_reg;
    logic [PW-1:0]        current_low_reg;
    logic [PW-1:0]        bar_counter_reg;
    logic [PW-1:0]        counter_inc;
    logic                 started_reg;

    logic [AW-1:0]        wr_ptr_reg;
    logic [AW-1:0]        wr_ptr_inc;
    logic [AW-1:0]        wr_ptr_dec;
    logic [AW-1:0]        rd_ptr_reg;
    logic [AW-1:0]        rd_ptr_dec;

    logic [PW-1:0]        pending_high_bar_reg;
    logic [PW-1:0]        pending_high_price_reg;
    logic [PW-1:0]        pending_low_bar_reg;
    logic [PW-1:0]        pending_low_price_reg;
    logic [PW-1:0]        swing_high_bar_reg;
    logic [PW-1:0]        swing_high_price_reg;
    logic                 swing_high_active_reg;
    logic [PW-1:0]        swing_low_bar_reg;
    logic [PW-1:0]        swing_low_price_reg;
    logic                 swing_low_active_reg;
    logic                 high_conf_reg;
    logic                 low_conf_reg;

    logic [PW-1:0]        win_max;
    logic [PW-1:0]        win_min;
    logic                 high_gate;
    logic                 high_breach;
    logic                 low_gate;
    logic                 low_breach;

    logic                 m_valid_reg;
    logic [PW-1:0]        bar_number_reg;
    logic [PW-1:0]        high_level_reg;
    logic                 high_shown_reg;
    logic [PW-1:0]        low_level_reg;
    logic                 low_shown_reg;
    logic                 high_confirmed_reg;
    logic [PW-1:0]        high_swing_bar_reg;
    logic                 low_confirmed_reg;
    logic [PW-1:0]        low_swing_bar_reg;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swing_length_reg <= slt_pkg::SWING_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            swing_length_reg <= cfg_wr_data;
        end
    end

    // Effective neighbour count, clamped to the range one to MAX_LEN.
    always_comb begin
        cfg_ext = CW'(swing_length_reg);
        if (cfg_ext == '0) begin
            len_eff = LW'(1);
        end else if (cfg_ext > CW'(MAX_LEN)) begin
            len_eff = LW'(MAX_LEN);
        end else begin
            len_eff = LW'(cfg_ext);
        end
    end

    assign len32       = PW'(len_reg);
    assign counter_inc = bar_counter_reg + PW'(1);

    // Ring pointer stepping with wrap at the memory depth.
    assign wr_ptr_inc = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
    assign wr_ptr_dec = (wr_ptr_reg == '0) ? AW'(DEPTH - 1) : wr_ptr_reg - AW'(1);
    assign rd_ptr_dec = (rd_ptr_reg == '0) ? AW'(DEPTH - 1) : rd_ptr_reg - AW'(1);

    assign out_free = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= slt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            slt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (started_reg && s_new_bar && (counter_inc > PW'(len_eff))) begin
                        state_next = slt_pkg::ST_SCAN;
                    end else begin
                        state_next = slt_pkg::ST_EVAL;
                    end
                end
            end
            slt_pkg::ST_SCAN: begin
                if (remain_reg == LW'(1)) begin
                    state_next = slt_pkg::ST_LAST;
                end
            end
            slt_pkg::ST_LAST:    state_next = slt_pkg::ST_DECIDE;
            slt_pkg::ST_DECIDE:  state_next = slt_pkg::ST_CONFIRM;
            slt_pkg::ST_CONFIRM: state_next = slt_pkg::ST_EVAL;
            slt_pkg::ST_EVAL: begin
                if (out_free) begin
                    state_next = slt_pkg::ST_IDLE;
                end
            end
            default: state_next = slt_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_ready             = 1'b0;
        out_load            = 1'b0;
        hist_ctrl.wr_en     = 1'b0;
        hist_ctrl.rd_en     = 1'b0;
        hist_ctrl.acc_clear = 1'b0;
        unique case (state_reg)
            slt_pkg::ST_IDLE: begin
                s_ready             = 1'b1;
                hist_ctrl.wr_en     = s_valid && started_reg && s_new_bar;
                hist_ctrl.acc_clear = s_valid;
            end
            slt_pkg::ST_SCAN: begin
                hist_ctrl.rd_en = 1'b1;
            end
            slt_pkg::ST_EVAL: begin
                out_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // History memory and shared window compare unit.
    slt_history #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_history (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (hist_ctrl),
        .wr_addr (wr_ptr_reg),
        .wr_high (current_high_reg),
        .wr_low  (current_low_reg),
        .rd_addr (rd_ptr_reg),
        .win_max (win_max),
        .win_min (win_min)
    );

    // Input capture, bar counting and ring pointers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_high_reg <= s_bar_high;
            in_low_reg  <= s_bar_low;
            len_reg     <= len_eff;
            remain_reg  <= len_eff;
            rd_ptr_reg  <= wr_ptr_dec;
        end else if (state_reg == slt_pkg::ST_SCAN) begin
            remain_reg <= remain_reg - LW'(1);
            rd_ptr_reg <= rd_ptr_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg     <= 1'b0;
            bar_counter_reg <= '0;
            wr_ptr_reg      <= '0;
        end else if (s_accept) begin
            if (!started_reg) begin
                started_reg     <= 1'b1;
                bar_counter_reg <= '0;
            end else if (s_new_bar) begin
                bar_counter_reg <= counter_inc;
                wr_ptr_reg      <= wr_ptr_inc;
            end
        end
    end

    // Pending pivots, confirmation and active levels.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_high_reg       <= '0;
            current_low_reg        <= '0;
            pending_high_bar_reg   <= '0;
            pending_high_price_reg <= '0;
            pending_low_bar_reg    <= '0;
            pending_low_price_reg  <= '0;
            swing_high_bar_reg     <= '0;
            swing_high_price_reg   <= '0;
            swing_high_active_reg  <= 1'b0;
            swing_low_bar_reg      <= '0;
            swing_low_price_reg    <= '0;
            swing_low_active_reg   <= 1'b0;
            high_conf_reg          <= 1'b0;
            low_conf_reg           <= 1'b0;
        end else begin
            if (s_accept) begin
                high_conf_reg <= 1'b0;
                low_conf_reg  <= 1'b0;
            end
            // The finished bar becomes pending if it beats the whole window.
            if (state_reg == slt_pkg::ST_DECIDE) begin
                if (current_high_reg > win_max) begin
                    pending_high_bar_reg   <= bar_counter_reg - PW'(1);
                    pending_high_price_reg <= current_high_reg;
                end
                if (current_low_reg < win_min) begin
                    pending_low_bar_reg   <= bar_counter_reg - PW'(1);
                    pending_low_price_reg <= current_low_reg;
                end
            end
            // A pending pivot is confirmed exactly N + 1 bars after its own bar.
            if (state_reg == slt_pkg::ST_CONFIRM) begin
                if ((pending_high_bar_reg >= len32) &&
                    ((bar_counter_reg - pending_high_bar_reg) == (len32 + PW'(1)))) begin
                    swing_high_bar_reg    <= pending_high_bar_reg;
                    swing_high_price_reg  <= pending_high_price_reg;
                    swing_high_active_reg <= 1'b1;
                    high_conf_reg         <= 1'b1;
                end
                if ((pending_low_bar_reg >= len32) &&
                    ((bar_counter_reg - pending_low_bar_reg) == (len32 + PW'(1)))) begin
                    swing_low_bar_reg    <= pending_low_bar_reg;
                    swing_low_price_reg  <= pending_low_price_reg;
                    swing_low_active_reg <= 1'b1;
                    low_conf_reg         <= 1'b1;
                end
            end
            // Final step: take the update as current bar and retire breached levels.
            if (out_load) begin
                current_high_reg <= in_high_reg;
                current_low_reg  <= in_low_reg;
                if (high_gate && high_breach) begin
                    swing_high_active_reg <= 1'b0;
                end
                if (low_gate && low_breach) begin
                    swing_low_active_reg <= 1'b0;
                end
            end
        end
    end

    // Level visibility for the current update.
    assign high_gate   = (swing_high_bar_reg >= len32) && swing_high_active_reg;
    assign high_breach = in_high_reg > swing_high_price_reg;
    assign low_gate    = (swing_low_bar_reg >= len32) && swing_low_active_reg;
    assign low_breach  = in_low_reg < swing_low_price_reg;

    // Output register: holds the result until its transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            bar_number_reg     <= bar_counter_reg;
            high_shown_reg     <= high_gate && !high_breach;
            high_level_reg     <= (high_gate && !high_breach) ? swing_high_price_reg : '0;
            low_shown_reg      <= low_gate && !low_breach;
            low_level_reg      <= (low_gate && !low_breach) ? swing_low_price_reg : '0;
            high_confirmed_reg <= high_conf_reg;
            high_swing_bar_reg <= high_conf_reg ? swing_high_bar_reg : '0;
            low_confirmed_reg  <= low_conf_reg;
            low_swing_bar_reg  <= low_conf_reg ? swing_low_bar_reg : '0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_bar_number     = bar_number_reg;
    assign m_high_level     = high_level_reg;
    assign m_high_shown     = high_shown_reg;
    assign m_low_level      = low_level_reg;
    assign m_low_shown      = low_shown_reg;
    assign m_high_confirmed = high_confirmed_reg;
    assign m_high_swing_bar = high_swing_bar_reg;
    assign m_low_confirmed  = low_confirmed_reg;
    assign m_low_swing_bar  = low_swing_bar_reg;

    // Assertions.
    `SLT_ASSERT_SAME(a_scan_count, state_reg == slt_pkg::ST_SCAN, remain_reg != '0, "scan with no reads left")
    `SLT_ASSERT_SAME(a_wr_ptr_range, started_reg, wr_ptr_reg <= AW'(DEPTH - 1), "write pointer out of range")
    `SLT_ASSERT_NEXT(a_started_sticky, started_reg, started_reg, "started flag cleared")
    `SLT_ASSERT_SAME(a_result_origin, $rose(m_valid_reg), $past(state_reg == slt_pkg::ST_EVAL), "result without final step")
    `SLT_ASSERT_NEXT(a_eval_hold, (state_reg == slt_pkg::ST_EVAL) && !out_free, state_reg == slt_pkg::ST_EVAL, "final step left while output held")

endmodule
